// ===== rtl/adamwu_pkg.sv =====
// ----------------------------------------------------------------------------
// adamwu_pkg
// shared types, widths and constants of the adam weight update block
// ----------------------------------------------------------------------------
package adamwu_pkg;

    localparam int NUM_LAYERS_DEF   = 8;
    localparam int NUM_ELEMENTS_DEF = 32768;

    localparam int LAYER_W = 3;
    localparam int ADDR_W  = 15;
    localparam int DATA_W  = 32;
    localparam int SQ_W    = 48;
    localparam int DEN_W   = 49;
    localparam int ACC_W   = 98;
    localparam int PADDR_W = 4;

    localparam logic [31:0] STEP_SIZE_RST    = 32'd4294967;
    localparam logic [31:0] DECAY_FIRST_RST  = 32'd3865470566;
    localparam logic [31:0] DECAY_SECOND_RST = 32'd4290672329;
    localparam logic [31:0] STABILIZER_RST   = 32'd43;

    localparam logic [31:0] SIGN32  = 32'h8000_0000;
    localparam logic [31:0] ONE32   = 32'd1;
    localparam logic [31:0] RND16   = 32'd32768;
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [63:0] UPDATE_CAP = 64'h2_0000_0000;

    typedef enum logic [1:0] {
        REG_STEP_SIZE,
        REG_DECAY_FIRST,
        REG_DECAY_SECOND,
        REG_STABILIZER
    } reg_idx_t;

    typedef enum logic [1:0] {
        MAC_NOP,
        MAC_SET,
        MAC_ADD,
        MAC_SUB
    } mac_op_t;

    typedef struct packed {
        mac_op_t     op;
        logic [1:0]  shift;
        logic [31:0] a;
        logic [31:0] b;
    } mac_cmd_t;

    typedef struct packed {
        logic start;
        logic rnd;
    } div_ctl_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_ROUND
    } div_state_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_MOM,
        ST_MHAT,
        ST_MHAT_W,
        ST_VHAT,
        ST_VHAT_W,
        ST_NUM,
        ST_NORM,
        ST_ROOT,
        ST_ROOT_W,
        ST_UPD,
        ST_UPD_W,
        ST_FIN
    } top_state_t;

endpackage

// ===== rtl/adamwu_mac.sv =====
// ----------------------------------------------------------------------------
// adamwu_mac
// shared 32x32 multiplier with a registered product and a wide accumulator
// ----------------------------------------------------------------------------
module adamwu_mac
    import adamwu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  mac_cmd_t         cmd,
    output logic [ACC_W-1:0] acc
);

    mac_op_t          op1_reg;
    logic [1:0]       sh1_reg;
    logic [63:0]      prod_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] term;

    assign term = ACC_W'(prod_reg) << {sh1_reg, 5'd0};
    assign acc  = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op1_reg <= MAC_NOP;
            sh1_reg <= 2'd0;
        end
        else
        begin
            op1_reg <= cmd.op;
            sh1_reg <= cmd.shift;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= cmd.a * cmd.b;
        case (op1_reg)
            MAC_SET: acc_reg <= term;
            MAC_ADD: acc_reg <= acc_reg + term;
            MAC_SUB: acc_reg <= acc_reg - term;
            default: acc_reg <= acc_reg;
        endcase
    end

endmodule

// ===== rtl/adamwu_div.sv =====
// ----------------------------------------------------------------------------
// adamwu_div
// restoring divider, one quotient bit a cycle, round half up and saturation
// ----------------------------------------------------------------------------
module adamwu_div
    import adamwu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctl_t         ctl,
    input  logic [63:0]      num_hi,
    input  logic [63:0]      num_lo,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [63:0]      quot
);

    div_state_t       state_reg;
    logic [6:0]       cnt_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [63:0]      lo_reg;
    logic [63:0]      quo_reg;
    logic             rnd_reg;
    logic             done_reg;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic [DEN_W:0]   rem_dbl;
    logic             fits;

    assign rem_sh   = {rem_reg, lo_reg[63]};
    assign fits     = rem_sh >= {1'b0, den_reg};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign rem_next = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    assign rem_dbl  = {rem_reg, 1'b0};
    assign done     = done_reg;
    assign quot     = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= 7'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                DIV_IDLE:
                begin
                    if (ctl.start)
                    begin
                        den_reg <= den;
                        rnd_reg <= ctl.rnd;
                        if (num_hi >= 64'(den))
                        begin
                            quo_reg  <= '1;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= num_hi[DEN_W-1:0];
                            lo_reg    <= num_lo;
                            quo_reg   <= 64'd0;
                            cnt_reg   <= 7'd64;
                            state_reg <= DIV_RUN;
                        end
                    end
                end
                DIV_RUN:
                begin
                    rem_reg <= rem_next;
                    quo_reg <= {quo_reg[62:0], fits};
                    lo_reg  <= {lo_reg[62:0], 1'b0};
                    cnt_reg <= cnt_reg - 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        state_reg <= DIV_ROUND;
                    end
                end
                DIV_ROUND:
                begin
                    if (rnd_reg && (rem_dbl >= {1'b0, den_reg}) && (quo_reg != '1))
                    begin
                        quo_reg <= quo_reg + 64'd1;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= DIV_IDLE;
                end
                default:
                begin
                    state_reg <= DIV_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/adamwu_sqrt.sv =====
// ----------------------------------------------------------------------------
// adamwu_sqrt
// bit-pair square root of a normalised 64-bit value, one result bit a cycle
// ----------------------------------------------------------------------------
module adamwu_sqrt
    import adamwu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] x_in,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [63:0] x_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [63:0] trial;
    logic        ge;

    assign trial = res_reg + bit_reg;
    assign ge    = x_reg >= trial;
    assign done  = done_reg;
    assign root  = res_reg[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    x_reg    <= x_in;
                    res_reg  <= 64'd0;
                    bit_reg  <= 64'h4000_0000_0000_0000;
                    busy_reg <= 1'b1;
                end
            end
            else
            begin
                if (ge)
                begin
                    x_reg   <= x_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== rtl/adam_weight_update_top.sv =====
// ----------------------------------------------------------------------------
// adam_weight_update_top
// adam optimiser weight update in fixed point, one element per input beat
// ----------------------------------------------------------------------------
// input beats carry layer, element address, gradient, weight and a pass end
// flag; each gives one output beat with the saturated new weight, the
// address as given and the flag. both channels use valid and stall.
// registers are written through the apb port; the user must do so only
// while the block is idle, which the block does not enforce. after reset
// the moment stores are zeroed one entry a cycle; in_stall stays high
// during that sweep. a beat passes address reduction, the store read, the
// moments and powers on the shared multiplier, divider passes for the
// corrected first and second moments, the update numerator on the
// multiplier, normalising, the root, a third divider pass for the update
// and the handover. one beat is worked at a time, and the next input beat
// is taken in the cycle after the previous result has been loaded.
// a finished beat waits in the output register while out_stall is high.
// ----------------------------------------------------------------------------
module adam_weight_update_top
    import adamwu_pkg::*;
#(
    parameter int NUM_LAYERS   = NUM_LAYERS_DEF,
    parameter int NUM_ELEMENTS = NUM_ELEMENTS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [LAYER_W-1:0]        layer_sel,
    input  logic [ADDR_W-1:0]         element_addr,
    input  logic signed [DATA_W-1:0]  grad_value,
    input  logic signed [DATA_W-1:0]  weight_value,
    input  logic                      pass_end,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [DATA_W-1:0]  new_weight,
    output logic [ADDR_W-1:0]         out_addr,
    output logic                      out_last
);

    localparam int AW  = $clog2(NUM_ELEMENTS);
    localparam int XW  = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int LW  = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int XLW = (LW > LAYER_W) ? LW : LAYER_W;
    localparam int CW  = $clog2(NUM_ELEMENTS + 1);

    top_state_t state_reg;
    top_state_t state_next;

    logic [31:0] step_size_reg;
    logic [31:0] decay_first_reg;
    logic [31:0] decay_second_reg;
    logic [31:0] stabilizer_reg;

    logic [CW-1:0]            clr_cnt_reg;
    logic [4:0]               pc_reg;
    logic [LAYER_W-1:0]       layer_reg;
    logic [ADDR_W-1:0]        addr_reg;
    logic [ADDR_W-1:0]        orig_addr_reg;
    logic [DATA_W-1:0]        grad_reg;
    logic signed [DATA_W-1:0] weight_reg;
    logic                     last_reg;

    logic [31:0]  m_reg;
    logic [47:0]  gsq_reg;
    logic [47:0]  v_reg;
    logic [31:0]  np1_reg;
    logic [31:0]  np2_reg;
    logic [63:0]  mhat_reg;
    logic [63:0]  s_reg;
    logic [127:0] num_reg;
    logic [31:0]  r_reg;
    logic [63:0]  q_reg;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] new_weight_reg;
    logic [ADDR_W-1:0]        out_addr_reg;
    logic                     out_last_reg;

    logic [31:0] mean_mem [NUM_ELEMENTS];
    logic [47:0] sq_mem   [NUM_ELEMENTS];
    logic [31:0] mean_q;
    logic [47:0] sq_q;
    logic [31:0] pow1_reg [NUM_LAYERS];
    logic [31:0] pow2_reg [NUM_LAYERS];

    logic [XW-1:0]  addr_x;
    logic [AW-1:0]  idx;
    logic [XLW-1:0] layer_x;
    logic [LW-1:0]  lidx;
    logic           addr_big;
    logic           layer_big;
    logic           in_take;
    logic           cfg_wr;
    logic           out_free;

    logic           mem_we;
    logic [AW-1:0]  mem_widx;
    logic [31:0]    mean_wd;
    logic [47:0]    sq_wd;

    logic [31:0]    p1;
    logic [31:0]    p2;
    logic [32:0]    d1;
    logic [32:0]    d2;
    logic [31:0]    ao;
    logic [31:0]    bo;
    logic [31:0]    gabs;
    logic [31:0]    mabs;
    logic [63:0]    mhat_num;
    logic [64:0]    s_sum;
    logic [63:0]    s_calc;

    logic [33:0]              qc;
    logic signed [35:0]       wv;
    logic signed [35:0]       res_w;
    logic signed [DATA_W-1:0] res_sat;

    mac_cmd_t         mac_cmd;
    logic [ACC_W-1:0] acc;
    div_ctl_t         div_ctl;
    logic [63:0]      div_hi;
    logic [63:0]      div_lo;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [63:0]      quot;
    logic             sq_start;
    logic             sq_done;
    logic [31:0]      root;

    adamwu_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (acc)
    );

    adamwu_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (div_ctl),
        .num_hi (div_hi),
        .num_lo (div_lo),
        .den    (div_den),
        .done   (div_done),
        .quot   (quot)
    );

    adamwu_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .x_in  (s_reg),
        .done  (sq_done),
        .root  (root)
    );

    // apb port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[3:2]))
            REG_STEP_SIZE:    prdata = step_size_reg;
            REG_DECAY_FIRST:  prdata = decay_first_reg;
            REG_DECAY_SECOND: prdata = decay_second_reg;
            REG_STABILIZER:   prdata = stabilizer_reg;
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg    <= STEP_SIZE_RST;
            decay_first_reg  <= DECAY_FIRST_RST;
            decay_second_reg <= DECAY_SECOND_RST;
            stabilizer_reg   <= STABILIZER_RST;
        end
        else if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[3:2]))
                REG_STEP_SIZE:    step_size_reg    <= pwdata;
                REG_DECAY_FIRST:  decay_first_reg  <= pwdata;
                REG_DECAY_SECOND: decay_second_reg <= pwdata;
                REG_STABILIZER:   stabilizer_reg   <= pwdata;
                default:          step_size_reg    <= step_size_reg;
            endcase
        end
    end

    // indices and derived operands
    assign addr_x    = XW'(addr_reg);
    assign idx       = addr_x[AW-1:0];
    assign layer_x   = XLW'(layer_reg);
    assign lidx      = layer_x[LW-1:0];
    assign addr_big  = 32'(addr_reg) >= 32'(NUM_ELEMENTS);
    assign layer_big = 32'(layer_reg) >= 32'(NUM_LAYERS);

    assign p1       = pow1_reg[lidx];
    assign p2       = pow2_reg[lidx];
    assign d1       = ONE_Q32 - {1'b0, p1};
    assign d2       = ONE_Q32 - {1'b0, p2};
    assign ao       = mean_q ^ SIGN32;
    assign bo       = grad_reg ^ SIGN32;
    assign gabs     = grad_reg[31] ? (32'd0 - grad_reg) : grad_reg;
    assign mabs     = m_reg[31] ? (32'd0 - m_reg) : m_reg;
    assign mhat_num = {mabs, 32'd0} + 64'(d1[32:1]);
    assign s_sum    = {1'b0, quot} + 65'(stabilizer_reg);

    always_comb
    begin
        if (s_sum[64])
        begin
            s_calc = '1;
        end
        else if (s_sum[63:0] == 64'd0)
        begin
            s_calc = 64'd1;
        end
        else
        begin
            s_calc = s_sum[63:0];
        end
    end

    // final update with cap and clamp
    assign qc    = (q_reg > UPDATE_CAP) ? UPDATE_CAP[33:0] : q_reg[33:0];
    assign wv    = 36'(weight_reg);
    assign res_w = m_reg[31] ? (wv + $signed({2'b00, qc})) : (wv - $signed({2'b00, qc}));

    always_comb
    begin
        if (res_w > 36'sd2147483647)
        begin
            res_sat = 32'sh7FFF_FFFF;
        end
        else if (res_w < -36'sd2147483648)
        begin
            res_sat = 32'sh8000_0000;
        end
        else
        begin
            res_sat = res_w[31:0];
        end
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign in_take  = in_valid && !in_stall;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and unit control
    always_comb
    begin
        state_next  = state_reg;
        mac_cmd     = '{op: MAC_NOP, shift: 2'd0, a: 32'd0, b: 32'd0};
        div_ctl     = '{start: 1'b0, rnd: 1'b0};
        div_hi      = 64'd0;
        div_lo      = mhat_num;
        div_den     = DEN_W'(d1);
        sq_start    = 1'b0;
        mem_we      = 1'b0;
        mem_widx    = idx;
        mean_wd     = m_reg;
        sq_wd       = v_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_widx = clr_cnt_reg[AW-1:0];
                mean_wd  = 32'd0;
                sq_wd    = 48'd0;
                if (clr_cnt_reg == CW'(NUM_ELEMENTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (!addr_big && !layer_big)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_MOM;
            end
            ST_MOM:
            begin
                case (pc_reg)
                    5'd0:  mac_cmd = '{op: MAC_SET, shift: 2'd0, a: SIGN32, b: ONE32};
                    5'd1:  mac_cmd = '{op: MAC_ADD, shift: 2'd1, a: bo, b: ONE32};
                    5'd2:  mac_cmd = '{op: MAC_ADD, shift: 2'd0, a: decay_first_reg, b: ao};
                    5'd3:  mac_cmd = '{op: MAC_SUB, shift: 2'd0, a: decay_first_reg, b: bo};
                    5'd4:  mac_cmd = '{op: MAC_SET, shift: 2'd0, a: gabs, b: gabs};
                    5'd5:  mac_cmd = '{op: MAC_ADD, shift: 2'd0, a: RND16, b: ONE32};
                    5'd6:  mac_cmd = '{op: MAC_SET, shift: 2'd0, a: SIGN32, b: ONE32};
                    5'd7:  mac_cmd = '{op: MAC_ADD, shift: 2'd0, a: decay_second_reg,
                                       b: sq_q[31:0]};
                    5'd8:  mac_cmd = '{op: MAC_ADD, shift: 2'd1, a: decay_second_reg,
                                       b: {16'd0, sq_q[47:32]}};
                    5'd9:  mac_cmd = '{op: MAC_ADD, shift: 2'd1, a: gsq_reg[31:0], b: ONE32};
                    5'd10: mac_cmd = '{op: MAC_ADD, shift: 2'd2, a: {16'd0, gsq_reg[47:32]},
                                       b: ONE32};
                    5'd11: mac_cmd = '{op: MAC_SUB, shift: 2'd0, a: decay_second_reg,
                                       b: gsq_reg[31:0]};
                    5'd12: mac_cmd = '{op: MAC_SUB, shift: 2'd1, a: decay_second_reg,
                                       b: {16'd0, gsq_reg[47:32]}};
                    5'd13: mac_cmd = '{op: MAC_SET, shift: 2'd0, a: SIGN32, b: ONE32};
                    5'd14: mac_cmd = '{op: MAC_ADD, shift: 2'd0, a: p1, b: decay_first_reg};
                    5'd15: mac_cmd = '{op: MAC_SET, shift: 2'd0, a: SIGN32, b: ONE32};
                    5'd16: mac_cmd = '{op: MAC_ADD, shift: 2'd0, a: p2, b: decay_second_reg};
                    default: mac_cmd = '{op: MAC_NOP, shift: 2'd0, a: 32'd0, b: 32'd0};
                endcase
                if (pc_reg == 5'd18)
                begin
                    state_next = ST_MHAT;
                end
            end
            ST_MHAT:
            begin
                div_ctl    = '{start: 1'b1, rnd: 1'b0};
                state_next = ST_MHAT_W;
            end
            ST_MHAT_W:
            begin
                if (div_done)
                begin
                    state_next = ST_VHAT;
                end
            end
            ST_VHAT:
            begin
                div_ctl    = '{start: 1'b1, rnd: 1'b1};
                div_hi     = 64'(v_reg[47:32]);
                div_lo     = {v_reg[31:0], 32'd0};
                div_den    = DEN_W'(d2);
                state_next = ST_VHAT_W;
            end
            ST_VHAT_W:
            begin
                if (div_done)
                begin
                    state_next = ST_NUM;
                end
            end
            ST_NUM:
            begin
                case (pc_reg)
                    5'd0:  mac_cmd = '{op: MAC_SET, shift: 2'd0, a: step_size_reg,
                                       b: mhat_reg[31:0]};
                    5'd1:  mac_cmd = '{op: MAC_ADD, shift: 2'd1, a: step_size_reg,
                                       b: mhat_reg[63:32]};
                    default: mac_cmd = '{op: MAC_NOP, shift: 2'd0, a: 32'd0, b: 32'd0};
                endcase
                if (pc_reg == 5'd3)
                begin
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (s_reg[63:62] != 2'b00)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                sq_start   = 1'b1;
                state_next = ST_ROOT_W;
            end
            ST_ROOT_W:
            begin
                if (sq_done)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                div_ctl    = '{start: 1'b1, rnd: 1'b1};
                div_hi     = num_reg[127:64];
                div_lo     = num_reg[63:0];
                div_den    = {1'b0, r_reg, 16'd0};
                state_next = ST_UPD_W;
            end
            ST_UPD_W:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            pc_reg        <= 5'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
            if (state_reg == ST_MOM || state_reg == ST_NUM)
            begin
                pc_reg <= pc_reg + 5'd1;
            end
            else
            begin
                pc_reg <= 5'd0;
            end
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // beta power terms per layer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LAYERS; i++)
            begin
                pow1_reg[i] <= DECAY_FIRST_RST;
                pow2_reg[i] <= DECAY_SECOND_RST;
            end
        end
        else if (state_reg == ST_FIN && out_free && last_reg)
        begin
            pow1_reg[lidx] <= np1_reg;
            pow2_reg[lidx] <= np2_reg;
        end
    end

    // moment stores
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mean_mem[mem_widx] <= mean_wd;
            sq_mem[mem_widx]   <= sq_wd;
        end
        mean_q <= mean_mem[idx];
        sq_q   <= sq_mem[idx];
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    layer_reg     <= layer_sel;
                    addr_reg      <= element_addr;
                    orig_addr_reg <= element_addr;
                    grad_reg      <= grad_value;
                    weight_reg    <= weight_value;
                    last_reg      <= pass_end;
                end
            end
            ST_REDUCE:
            begin
                if (addr_big)
                begin
                    addr_reg <= addr_reg - ADDR_W'(NUM_ELEMENTS);
                end
                if (layer_big)
                begin
                    layer_reg <= layer_reg - LAYER_W'(NUM_LAYERS);
                end
            end
            ST_MOM:
            begin
                case (pc_reg)
                    5'd5:    m_reg   <= acc[63:32] ^ SIGN32;
                    5'd7:    gsq_reg <= acc[63:16];
                    5'd14:   v_reg   <= acc[79:32];
                    5'd16:   np1_reg <= acc[63:32];
                    5'd18:   np2_reg <= acc[63:32];
                    default: m_reg   <= m_reg;
                endcase
            end
            ST_MHAT_W:
            begin
                if (div_done)
                begin
                    mhat_reg <= quot;
                end
            end
            ST_VHAT_W:
            begin
                if (div_done)
                begin
                    s_reg <= s_calc;
                end
            end
            ST_NUM:
            begin
                if (pc_reg == 5'd3)
                begin
                    num_reg <= 128'(acc);
                end
            end
            ST_NORM:
            begin
                if (s_reg[63:62] == 2'b00)
                begin
                    s_reg   <= {s_reg[61:0], 2'b00};
                    num_reg <= {num_reg[126:0], 1'b0};
                end
            end
            ST_ROOT_W:
            begin
                if (sq_done)
                begin
                    r_reg <= root;
                end
            end
            ST_UPD_W:
            begin
                if (div_done)
                begin
                    q_reg <= quot;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    new_weight_reg <= res_sat;
                    out_addr_reg   <= orig_addr_reg;
                    out_last_reg   <= last_reg;
                end
            end
            default:
            begin
                q_reg <= q_reg;
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign new_weight = new_weight_reg;
    assign out_addr   = out_addr_reg;
    assign out_last   = out_last_reg;

endmodule
